/* design/ibfs_pkg.sv */
// shared types and codes of the indexed block file store
package ibfs_pkg;

	localparam int DISK_BYTES = 256;
	localparam int MAX_FILES  = 16;
	localparam int BM_BITS    = 16;
	localparam int BM_WORDS   = DISK_BYTES / 2 / BM_BITS;
	localparam int DISK_AW    = $clog2(DISK_BYTES);
	localparam int TBL_AW     = $clog2(MAX_FILES);
	localparam int BM_AW      = $clog2(BM_WORDS);

	localparam logic [7:0] NO_BLOCK = 8'hFF;

	typedef logic [4:0] bsz_t;

	localparam logic [2:0] ACT_FORMAT = 3'd0;
	localparam logic [2:0] ACT_CREATE = 3'd1;
	localparam logic [2:0] ACT_OPEN   = 3'd2;
	localparam logic [2:0] ACT_CLOSE  = 3'd3;
	localparam logic [2:0] ACT_WRITE  = 3'd4;
	localparam logic [2:0] ACT_READ   = 3'd5;
	localparam logic [2:0] ACT_DELETE = 3'd6;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_UNFMT   = 3'd1;
	localparam logic [2:0] ST_NOFILE  = 3'd2;
	localparam logic [2:0] ST_NOTOPEN = 3'd3;
	localparam logic [2:0] ST_ALREADY = 3'd4;
	localparam logic [2:0] ST_NOSPACE = 3'd5;
	localparam logic [2:0] ST_BADFD   = 3'd6;
	localparam logic [2:0] ST_BEYOND  = 3'd7;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] name_key;
		logic [7:0]  file_id;
		logic [7:0]  data_byte;
		logic [7:0]  position;
		logic [8:0]  length;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  result_fd;
		logic [7:0]  read_byte;
		logic [31:0] closed_key;
	} rsp_t;

endpackage

/* design/ibfs_if.sv */
// request and result channel interfaces
interface ibfs_req_if;
	logic valid;
	logic ready;
	ibfs_pkg::req_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface ibfs_rsp_if;
	logic valid;
	logic ready;
	ibfs_pkg::rsp_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* design/indexed_block_file_store_core.sv */
// A byte store of 256 bytes with indexed file allocation. One request gives one result.
// Requests are handled one at a time; each memory step sets a read address, waits for the
// registered data and writes back. Format runs a clearing sweep of the disk memory and the
// bitmap, then a divide; open, close, write and read scan the file table entry by entry,
// plus a divide and two disk reads for a read; create scans the whole table and then the
// block bitmap one 16-block word at a time; delete frees the index block, zeroes and frees
// each data block, clears the index entries and moves the later table entries down. A
// finished result waits in the output register while the next request is taken.
module indexed_block_file_store_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  ibfs_pkg::bsz_t cfg_wdata,
	ibfs_req_if.sink       req,
	ibfs_rsp_if.source     rsp
);
	import ibfs_pkg::*;

	typedef struct packed {
		logic [31:0] key;
		logic [7:0]  fd;
		logic        is_open;
		logic [8:0]  size;
		logic [6:0]  iblk;
		logic [7:0]  dblk;
		logic [4:0]  offs;
	} entry_t;

	typedef enum logic [5:0] {
		S_IDLE, S_DEC, S_FCLR, S_FDIV_DONE,
		S_SCAN, S_SCAN_WT, S_SCAN_CMP, S_SCAN_END,
		S_CR_DONE, S_WR_TAKEN, S_WR_IDX, S_WR_DATA,
		S_RD_IDX, S_RD_WT1, S_RD_BLK, S_RD_WT2, S_RD_BYTE,
		S_DEL_N, S_DEL_LOOP, S_DEL_WT, S_DEL_BLK, S_DEL_ZERO, S_DEL_NEXT,
		S_DEL_IDXZ, S_DEL_SH, S_DEL_SH_WT, S_DEL_SH_WR, S_DEL_END,
		S_TK, S_TK_RD, S_TK_WT, S_TK_CHK,
		S_FR, S_FR_WT, S_FR_CHK,
		S_DIV, S_FIN
	} state_t;

	function automatic logic [DISK_AW-1:0] daddr(input logic [4:0] b, input logic [7:0] blk,
			input logic [8:0] off);
		logic [13:0] p;
		p = 14'(b) * 14'(blk) + 14'(off);
		return p[DISK_AW-1:0];
	endfunction

	state_t state_q, ret_q;

	logic [2:0]  act_q;
	logic [31:0] key_q;
	logic [7:0]  fid_q, dat_q, pos_q;
	logic [8:0]  len_q;

	bsz_t        cfg_bs_q, bs_q;
	logic [7:0]  total_q, free_q;
	logic [8:0]  cap_q;
	logic        fmt_q;
	logic [4:0]  count_q;

	logic [4:0]  idx_q;
	logic        found_q, any_q;
	logic [7:0]  maxfd_q;
	logic [3:0]  e_q;
	entry_t      ent_q;

	logic [8:0]  dvd_q, quo_q;
	logic [3:0]  rem_q, dcnt_q;

	logic [3:0]  wrd_q;
	logic        tk_ok_q;
	logic [6:0]  tblk_q;
	logic [7:0]  fblk_q;

	logic [4:0]  nblk_q, i_q, j_q;
	logic [7:0]  blk_q, clr_q;

	logic [2:0]  st_q;
	logic [7:0]  rfd_q, rbyte_q;
	logic [31:0] ckey_q;

	logic        out_valid_q;
	rsp_t        out_q;

	logic               dk_we_q;
	logic [DISK_AW-1:0] dk_wa_q, dk_ra_q;
	logic [7:0]         dk_wd_q, dk_rd;
	logic               tb_we_q;
	logic [TBL_AW-1:0]  tb_wa_q, tb_ra_q;
	entry_t             tb_wd_q, tb_rd;
	logic               bm_we_q;
	logic [BM_AW-1:0]   bm_wa_q, bm_ra_q;
	logic [BM_BITS-1:0] bm_wd_q, bm_rd;

	ibfs_ram #(.WIDTH(8), .DEPTH(DISK_BYTES)) u_disk (
		.clk(clk), .we(dk_we_q), .waddr(dk_wa_q), .wdata(dk_wd_q), .raddr(dk_ra_q), .rdata(dk_rd)
	);
	ibfs_ram #(.WIDTH($bits(entry_t)), .DEPTH(MAX_FILES)) u_table (
		.clk(clk), .we(tb_we_q), .waddr(tb_wa_q), .wdata(tb_wd_q), .raddr(tb_ra_q), .rdata(tb_rd)
	);
	ibfs_ram #(.WIDTH(BM_BITS), .DEPTH(BM_WORDS)) u_bitmap (
		.clk(clk), .we(bm_we_q), .waddr(bm_wa_q), .wdata(bm_wd_q), .raddr(bm_ra_q), .rdata(bm_rd)
	);

	logic               accept;
	logic [BM_BITS-1:0] elig, avail;
	logic [3:0]         first_k;
	logic [4:0]         div_t;
	logic               div_ge;
	logic [7:0]         new_fd;
	bsz_t               sat_bs;
	logic [9:0]         sq;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.payload = out_q;

	assign div_t  = {rem_q, dvd_q[8]};
	assign div_ge = (div_t >= bs_q);
	assign new_fd = any_q ? maxfd_q + 8'd1 : 8'd0;
	assign sat_bs = (cfg_bs_q < 5'd2) ? 5'd2 : ((cfg_bs_q > 5'd16) ? 5'd16 : cfg_bs_q);
	assign sq     = 10'(sat_bs) * 10'(sat_bs);

	// blocks of the scanned bitmap word that lie below the block total
	always_comb begin
		for (int k = 0; k < BM_BITS; k++) begin
			elig[k] = ({1'b0, wrd_q[BM_AW-1:0], 4'(k)} < total_q);
		end
		avail   = ~bm_rd & elig;
		first_k = '0;
		for (int k = BM_BITS - 1; k >= 0; k--) begin
			if (avail[k]) first_k = 4'(k);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
			act_q <= '0; key_q <= '0; fid_q <= '0; dat_q <= '0; pos_q <= '0; len_q <= '0;
			cfg_bs_q <= 5'd4; bs_q <= 5'd4; total_q <= 8'd64; cap_q <= 9'd16;
			free_q <= '0; fmt_q <= 1'b0; count_q <= '0;
			idx_q <= '0; found_q <= 1'b0; any_q <= 1'b0; maxfd_q <= '0; e_q <= '0; ent_q <= '0;
			dvd_q <= '0; quo_q <= '0; rem_q <= '0; dcnt_q <= '0;
			wrd_q <= '0; tk_ok_q <= 1'b0; tblk_q <= '0; fblk_q <= '0;
			nblk_q <= '0; i_q <= '0; j_q <= '0; blk_q <= '0; clr_q <= '0;
			st_q <= '0; rfd_q <= '0; rbyte_q <= '0; ckey_q <= '0;
			out_valid_q <= 1'b0; out_q <= '0;
			dk_we_q <= 1'b0; dk_wa_q <= '0; dk_wd_q <= '0; dk_ra_q <= '0;
			tb_we_q <= 1'b0; tb_wa_q <= '0; tb_wd_q <= '0; tb_ra_q <= '0;
			bm_we_q <= 1'b0; bm_wa_q <= '0; bm_wd_q <= '0; bm_ra_q <= '0;
		end else begin
			dk_we_q <= 1'b0;
			tb_we_q <= 1'b0;
			bm_we_q <= 1'b0;
			if (cfg_we) begin
				cfg_bs_q <= cfg_wdata;
			end
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						act_q <= req.payload.action;
						key_q <= req.payload.name_key;
						fid_q <= req.payload.file_id;
						dat_q <= req.payload.data_byte;
						pos_q <= req.payload.position;
						len_q <= req.payload.length;
						st_q <= ST_OK; rfd_q <= '0; rbyte_q <= '0; ckey_q <= '0;
						idx_q <= '0; found_q <= 1'b0; any_q <= 1'b0; maxfd_q <= '0;
						state_q <= S_DEC;
					end
				end

				S_DEC: begin
					unique case (act_q)
						ACT_FORMAT: begin
							bs_q    <= sat_bs;
							cap_q   <= sq[8:0];
							clr_q   <= '0;
							state_q <= S_FCLR;
						end
						ACT_CREATE, ACT_WRITE: begin
							if (!fmt_q) begin
								st_q    <= ST_UNFMT;
								state_q <= S_FIN;
							end else begin
								state_q <= S_SCAN;
							end
						end
						ACT_OPEN, ACT_CLOSE, ACT_READ, ACT_DELETE: state_q <= S_SCAN;
						default: state_q <= S_FIN;
					endcase
				end

				// zero the disk and the bitmap, then work out the block total
				S_FCLR: begin
					dk_we_q <= 1'b1;
					dk_wa_q <= clr_q[DISK_AW-1:0];
					dk_wd_q <= '0;
					if (clr_q < 8'(BM_WORDS)) begin
						bm_we_q <= 1'b1;
						bm_wa_q <= clr_q[BM_AW-1:0];
						bm_wd_q <= '0;
					end
					clr_q <= clr_q + 8'd1;
					if (clr_q == 8'(DISK_BYTES - 1)) begin
						dvd_q <= 9'(DISK_BYTES); rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
						ret_q <= S_FDIV_DONE;
						state_q <= S_DIV;
					end
				end

				S_FDIV_DONE: begin
					free_q  <= quo_q[7:0];
					total_q <= quo_q[7:0];
					count_q <= '0;
					fmt_q   <= 1'b1;
					state_q <= S_FIN;
				end

				S_SCAN: begin
					if (idx_q == count_q) begin
						state_q <= S_SCAN_END;
					end else begin
						tb_ra_q <= idx_q[TBL_AW-1:0];
						state_q <= S_SCAN_WT;
					end
				end

				S_SCAN_WT: state_q <= S_SCAN_CMP;

				S_SCAN_CMP: begin
					idx_q   <= idx_q + 5'd1;
					state_q <= S_SCAN;
					unique case (act_q)
						ACT_CREATE: begin
							if (!any_q || tb_rd.fd > maxfd_q) begin
								maxfd_q <= tb_rd.fd;
								any_q   <= 1'b1;
							end
						end
						ACT_OPEN: begin
							if (tb_rd.key == key_q) begin
								found_q <= 1'b1; e_q <= idx_q[TBL_AW-1:0]; ent_q <= tb_rd;
								state_q <= S_SCAN_END;
							end
						end
						ACT_DELETE: begin
							// last match wins
							if (tb_rd.key == key_q) begin
								found_q <= 1'b1; e_q <= idx_q[TBL_AW-1:0]; ent_q <= tb_rd;
							end
						end
						default: begin
							if (tb_rd.fd == fid_q) begin
								found_q <= 1'b1; e_q <= idx_q[TBL_AW-1:0]; ent_q <= tb_rd;
								state_q <= S_SCAN_END;
							end
						end
					endcase
				end

				S_SCAN_END: begin
					state_q <= S_FIN;
					unique case (act_q)
						ACT_CREATE: begin
							if (free_q <= 8'd1 || count_q >= 5'(MAX_FILES)
									|| (any_q && maxfd_q == 8'hFF)) begin
								st_q <= ST_NOSPACE;
							end else begin
								ret_q   <= S_CR_DONE;
								state_q <= S_TK;
							end
						end
						ACT_OPEN: begin
							if (!found_q) begin
								st_q <= ST_NOFILE;
							end else if (ent_q.is_open) begin
								st_q <= ST_ALREADY;
							end else begin
								tb_we_q <= 1'b1; tb_wa_q <= e_q;
								tb_wd_q <= ent_q; tb_wd_q.is_open <= 1'b1;
								rfd_q <= ent_q.fd;
							end
						end
						ACT_CLOSE: begin
							if (!found_q || !ent_q.is_open) begin
								st_q <= ST_BADFD;
							end else begin
								tb_we_q <= 1'b1; tb_wa_q <= e_q;
								tb_wd_q <= ent_q; tb_wd_q.is_open <= 1'b0;
								ckey_q <= ent_q.key;
							end
						end
						ACT_WRITE: begin
							if (!found_q) begin
								st_q <= ST_BADFD;
							end else if (!ent_q.is_open) begin
								st_q <= ST_NOTOPEN;
							end else if (ent_q.size >= cap_q) begin
								st_q <= ST_NOSPACE;
							end else if (ent_q.dblk == NO_BLOCK || ent_q.offs >= bs_q) begin
								ret_q   <= S_WR_TAKEN;
								state_q <= S_TK;
							end else begin
								state_q <= S_WR_DATA;
							end
						end
						ACT_READ: begin
							if (!found_q) begin
								st_q <= ST_BADFD;
							end else if (!ent_q.is_open) begin
								st_q <= ST_NOTOPEN;
							end else if ({1'b0, pos_q} >= len_q || {1'b0, pos_q} >= ent_q.size) begin
								st_q <= ST_BEYOND;
							end else begin
								dvd_q <= {1'b0, pos_q}; rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
								ret_q <= S_RD_IDX;
								state_q <= S_DIV;
							end
						end
						ACT_DELETE: begin
							if (!found_q) begin
								st_q <= ST_NOFILE;
							end else if (!ent_q.is_open) begin
								st_q <= ST_NOTOPEN;
							end else begin
								dvd_q <= ent_q.size + 9'(bs_q) - 9'd1;
								rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
								ret_q <= S_DEL_N;
								state_q <= S_DIV;
							end
						end
						default: state_q <= S_FIN;
					endcase
				end

				S_CR_DONE: begin
					if (!tk_ok_q) begin
						st_q <= ST_NOSPACE;
					end else begin
						tb_we_q <= 1'b1;
						tb_wa_q <= count_q[TBL_AW-1:0];
						tb_wd_q <= '{key: key_q, fd: new_fd, is_open: 1'b1, size: '0,
							iblk: tblk_q, dblk: NO_BLOCK, offs: '0};
						count_q <= count_q + 5'd1;
						rfd_q   <= new_fd;
					end
					state_q <= S_FIN;
				end

				S_WR_TAKEN: begin
					if (!tk_ok_q) begin
						st_q    <= ST_NOSPACE;
						state_q <= S_FIN;
					end else begin
						ent_q.offs <= '0;
						ent_q.dblk <= {1'b0, tblk_q};
						dvd_q <= ent_q.size; rem_q <= '0; quo_q <= '0; dcnt_q <= '0;
						ret_q <= S_WR_IDX;
						state_q <= S_DIV;
					end
				end

				// record the new data block in the index block
				S_WR_IDX: begin
					dk_we_q <= 1'b1;
					dk_wa_q <= daddr(bs_q, {1'b0, ent_q.iblk}, quo_q);
					dk_wd_q <= {1'b0, tblk_q};
					state_q <= S_WR_DATA;
				end

				S_WR_DATA: begin
					dk_we_q <= 1'b1;
					dk_wa_q <= daddr(bs_q, ent_q.dblk, {4'b0, ent_q.offs});
					dk_wd_q <= dat_q;
					tb_we_q <= 1'b1;
					tb_wa_q <= e_q;
					tb_wd_q <= ent_q;
					tb_wd_q.offs <= ent_q.offs + 5'd1;
					tb_wd_q.size <= ent_q.size + 9'd1;
					state_q <= S_FIN;
				end

				S_RD_IDX: begin
					dk_ra_q <= daddr(bs_q, {1'b0, ent_q.iblk}, quo_q);
					state_q <= S_RD_WT1;
				end
				S_RD_WT1: state_q <= S_RD_BLK;
				S_RD_BLK: begin
					dk_ra_q <= daddr(bs_q, dk_rd, {5'b0, rem_q});
					state_q <= S_RD_WT2;
				end
				S_RD_WT2: state_q <= S_RD_BYTE;
				S_RD_BYTE: begin
					rbyte_q <= dk_rd;
					state_q <= S_FIN;
				end

				S_DEL_N: begin
					nblk_q  <= quo_q[4:0];
					fblk_q  <= {1'b0, ent_q.iblk};
					i_q     <= '0;
					ret_q   <= S_DEL_LOOP;
					state_q <= S_FR;
				end

				S_DEL_LOOP: begin
					if (i_q == nblk_q) begin
						i_q     <= '0;
						state_q <= S_DEL_IDXZ;
					end else begin
						dk_ra_q <= daddr(bs_q, {1'b0, ent_q.iblk}, {4'b0, i_q});
						state_q <= S_DEL_WT;
					end
				end
				S_DEL_WT: state_q <= S_DEL_BLK;
				S_DEL_BLK: begin
					blk_q   <= dk_rd;
					j_q     <= '0;
					state_q <= S_DEL_ZERO;
				end

				S_DEL_ZERO: begin
					dk_we_q <= 1'b1;
					dk_wa_q <= daddr(bs_q, blk_q, {4'b0, j_q});
					dk_wd_q <= '0;
					j_q     <= j_q + 5'd1;
					if (j_q == bs_q - 5'd1) begin
						fblk_q  <= blk_q;
						ret_q   <= S_DEL_NEXT;
						state_q <= S_FR;
					end
				end

				S_DEL_NEXT: begin
					i_q     <= i_q + 5'd1;
					state_q <= S_DEL_LOOP;
				end

				S_DEL_IDXZ: begin
					if (i_q == nblk_q) begin
						idx_q   <= {1'b0, e_q};
						state_q <= S_DEL_SH;
					end else begin
						dk_we_q <= 1'b1;
						dk_wa_q <= daddr(bs_q, {1'b0, ent_q.iblk}, {4'b0, i_q});
						dk_wd_q <= '0;
						i_q     <= i_q + 5'd1;
					end
				end

				// close the gap in the file table
				S_DEL_SH: begin
					if (idx_q + 5'd1 >= count_q) begin
						state_q <= S_DEL_END;
					end else begin
						tb_ra_q <= TBL_AW'(idx_q + 5'd1);
						state_q <= S_DEL_SH_WT;
					end
				end
				S_DEL_SH_WT: state_q <= S_DEL_SH_WR;
				S_DEL_SH_WR: begin
					tb_we_q <= 1'b1;
					tb_wa_q <= idx_q[TBL_AW-1:0];
					tb_wd_q <= tb_rd;
					idx_q   <= idx_q + 5'd1;
					state_q <= S_DEL_SH;
				end

				S_DEL_END: begin
					count_q <= count_q - 5'd1;
					rfd_q   <= ent_q.fd;
					state_q <= S_FIN;
				end

				// first free block, one bitmap word at a time
				S_TK: begin
					wrd_q <= '0;
					if (free_q == 8'd0) begin
						tk_ok_q <= 1'b0;
						state_q <= ret_q;
					end else begin
						state_q <= S_TK_RD;
					end
				end
				S_TK_RD: begin
					if (wrd_q == 4'(BM_WORDS) || {wrd_q, 4'b0} >= total_q) begin
						tk_ok_q <= 1'b0;
						state_q <= ret_q;
					end else begin
						bm_ra_q <= wrd_q[BM_AW-1:0];
						state_q <= S_TK_WT;
					end
				end
				S_TK_WT: state_q <= S_TK_CHK;
				S_TK_CHK: begin
					if (avail != '0) begin
						tblk_q  <= {wrd_q[BM_AW-1:0], first_k};
						bm_we_q <= 1'b1;
						bm_wa_q <= wrd_q[BM_AW-1:0];
						bm_wd_q <= bm_rd | (BM_BITS'(1) << first_k);
						free_q  <= free_q - 8'd1;
						tk_ok_q <= 1'b1;
						state_q <= ret_q;
					end else begin
						wrd_q   <= wrd_q + 4'd1;
						state_q <= S_TK_RD;
					end
				end

				// release a block only if it is in range and marked used
				S_FR: begin
					if (fblk_q >= total_q) begin
						state_q <= ret_q;
					end else begin
						bm_ra_q <= fblk_q[6:4];
						state_q <= S_FR_WT;
					end
				end
				S_FR_WT: state_q <= S_FR_CHK;
				S_FR_CHK: begin
					if (bm_rd[fblk_q[3:0]]) begin
						bm_we_q <= 1'b1;
						bm_wa_q <= fblk_q[6:4];
						bm_wd_q <= bm_rd & ~(BM_BITS'(1) << fblk_q[3:0]);
						free_q  <= free_q + 8'd1;
					end
					state_q <= ret_q;
				end

				// restoring divide by the block size, one quotient bit a cycle
				S_DIV: begin
					rem_q  <= div_ge ? 4'(div_t - bs_q) : div_t[3:0];
					quo_q  <= {quo_q[7:0], div_ge};
					dvd_q  <= {dvd_q[7:0], 1'b0};
					dcnt_q <= dcnt_q + 4'd1;
					if (dcnt_q == 4'd8) begin
						state_q <= ret_q;
					end
				end

				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						out_q <= '{status: st_q, result_fd: rfd_q, read_byte: rbyte_q,
							closed_key: ckey_q};
						state_q <= S_IDLE;
					end
				end

				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 5'(MAX_FILES))
		else $error("file count above table depth");

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= total_q)
		else $error("free block count above block total");

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> state_q == S_DEC)
		else $error("accepted request not decoded");

endmodule

/* design/ibfs_ram.sv */
// generic single write port ram with registered read
module ibfs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
